// ===== rtl/core/circular_double_ended_queue_top_assert.svh =====
// Assertion macros shared by the checker of the deque block.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDEQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque check failed");

// The consequent must hold in the cycle after the antecedent.
`define CDEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

// ===== rtl/core/cdeq_pkg.sv =====
`timescale 1ns / 1ps

package cdeq_pkg;

  // Storage geometry.
  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the stream channels.
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int OCC_W      = 4;
  localparam int S_TDATA_W  = IN_DATA_W;
  localparam int M_TDATA_W  = ((OUT_DATA_W + OCC_W + 7) / 8) * 8;
  localparam int M_PAD_W    = M_TDATA_W - OUT_DATA_W - OCC_W;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_READ_ALL   = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  // Operation applied to every cell of the row together.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_ROTATE
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  // Command from the controller to the cell row.
  typedef struct packed {
    op_e   op;
    word_t value;
  } chain_cmd_t;

  // Words the controller picks up from the row.
  typedef struct packed {
    word_t head;
    word_t tail;
  } chain_rd_t;

  // Bring a 32-bit input word to the stored width (sign extend or truncate).
  function automatic word_t take_word(logic signed [IN_DATA_W-1:0] v);
    return DATA_WIDTH'(v);
  endfunction

  // Bring a stored word back to the 32-bit output (sign extend or truncate).
  function automatic logic signed [OUT_DATA_W-1:0] give_word(word_t w);
    return OUT_DATA_W'(w);
  endfunction

endpackage

// ===== rtl/core/cdeq_cell.sv =====
`timescale 1ns / 1ps

module cdeq_cell (
  input  logic            clk_i,
  input  cdeq_pkg::op_e   op_i,
  input  cdeq_pkg::word_t value_i,
  input  cdeq_pkg::word_t left_i,
  input  cdeq_pkg::word_t right_i,
  input  cdeq_pkg::word_t head_i,
  input  logic            wr_sel_i,
  input  logic            tail_i,
  output cdeq_pkg::word_t data_o
);
  import cdeq_pkg::*;

  word_t data_q;
  word_t data_d;

  // Pick the next word from a neighbor, the new value or the head.
  always_comb begin
    data_d = data_q;
    case (op_i)
      OP_PUSH_FRONT: data_d = left_i;
      OP_PUSH_BACK: begin
        if (wr_sel_i) begin
          data_d = value_i;
        end
      end
      OP_POP_FRONT:  data_d = right_i;
      OP_ROTATE:     data_d = tail_i ? head_i : right_i;
      default:       data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/cdeq_chain.sv =====
`timescale 1ns / 1ps

module cdeq_chain (
  input  logic                 clk_i,
  input  cdeq_pkg::chain_cmd_t cmd_i,
  input  cdeq_pkg::cnt_t       count_i,
  output cdeq_pkg::chain_rd_t  rd_o
);
  import cdeq_pkg::*;

  word_t             cell_data [DEPTH];
  logic [DEPTH-1:0]  wr_sel;
  logic [DEPTH-1:0]  tail_sel;

  // Row of cells; cell 0 holds the front entry, cell count-1 the back entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_w;
    word_t right_w;

    assign wr_sel[i]   = (count_i == CNT_W'(i));
    assign tail_sel[i] = (count_i == CNT_W'(i + 1));

    if (i == 0) begin : g_first
      assign left_w = cmd_i.value;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    cdeq_cell u_cell (
      .clk_i    (clk_i),
      .op_i     (cmd_i.op),
      .value_i  (cmd_i.value),
      .left_i   (left_w),
      .right_i  (right_w),
      .head_i   (cell_data[0]),
      .wr_sel_i (wr_sel[i]),
      .tail_i   (tail_sel[i]),
      .data_o   (cell_data[i])
    );
  end

  // The back entry is selected by the one-hot tail flag.
  always_comb begin
    rd_o.head = cell_data[0];
    rd_o.tail = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tail_sel[i]) begin
        rd_o.tail = rd_o.tail | cell_data[i];
      end
    end
  end

endmodule

// ===== rtl/core/circular_double_ended_queue_top.sv =====
`timescale 1ns / 1ps

// Double-ended queue of signed words held in a row of storage cells.
// Input channel (s_axis): tuser carries the operation kind, tdata the word
// to push. Kinds: push front, push back, pop front, pop back, read out all.
// Output channel (m_axis): tuser carries the status, tdata the returned word
// and the occupancy after the operation, tlast marks the final result of an
// input transfer.
// A push or pop gives a single result that appears in the output register on
// the next cycle, so one push or pop per cycle is sustained while the
// receiver keeps tready high.
// A read-out of N entries is accepted, then returns the entries one result at a
// time from the head, while the cells rotate them past the head and end in
// their original order. No input is taken meanwhile.
// Overflow, underflow and an empty read-out give one result with zero data.
// Unused kind codes are accepted and give no result.
// Reset empties the queue and drops any pending result.
// When the receiver stalls, the output register holds its result and no new
// input transfer is taken until that result has gone.
module circular_double_ended_queue_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cdeq_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [31:0] value
  input  logic [cdeq_pkg::KIND_W-1:0]    s_axis_tuser,  // [2:0] kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [cdeq_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [31:0] data, [35:32] occupancy
  output logic [cdeq_pkg::STATUS_W-1:0]  m_axis_tuser,  // [1:0] status
  output logic                           m_axis_tlast
);
  import cdeq_pkg::*;

  state_e     state_q, state_d;
  cnt_t       count_q, count_d;
  cnt_t       remain_q, remain_d;
  logic       out_valid_q, out_valid_d;
  status_e    out_status_q, out_status_d;
  logic signed [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic       out_last_q, out_last_d;
  logic [OCC_W-1:0] out_occ_q;
  logic       emit;
  logic       slot_free;
  logic       in_fire;
  logic       is_full;
  logic       is_empty;
  chain_cmd_t cmd;
  chain_rd_t  rd;

  cdeq_chain u_chain (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .count_i (count_q),
    .rd_o    (rd)
  );

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_full       = (count_q == CNT_W'(DEPTH));
  assign is_empty      = (count_q == '0);

  // Operation decode, read-out sequencing and result formation.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    remain_d     = remain_q;
    cmd.op       = OP_HOLD;
    cmd.value    = take_word(s_axis_tdata);
    emit         = 1'b0;
    out_status_d = STATUS_OK;
    out_data_d   = '0;
    out_last_d   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (kind_e'(s_axis_tuser))
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              emit = 1'b1;
              if (is_full) begin
                out_status_d = STATUS_OVERFLOW;
              end else begin
                cmd.op  = (kind_e'(s_axis_tuser) == KIND_PUSH_FRONT) ?
                          OP_PUSH_FRONT : OP_PUSH_BACK;
                count_d = count_q + CNT_W'(1);
              end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
              emit = 1'b1;
              if (is_empty) begin
                out_status_d = STATUS_UNDERFLOW;
              end else if (kind_e'(s_axis_tuser) == KIND_POP_FRONT) begin
                cmd.op     = OP_POP_FRONT;
                out_data_d = give_word(rd.head);
                count_d    = count_q - CNT_W'(1);
              end else begin
                out_data_d = give_word(rd.tail);
                count_d    = count_q - CNT_W'(1);
              end
            end
            KIND_READ_ALL: begin
              if (is_empty) begin
                emit         = 1'b1;
                out_status_d = STATUS_EMPTY;
              end else begin
                remain_d = count_q;
                state_d  = ST_DUMP;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          emit       = 1'b1;
          cmd.op     = OP_ROTATE;
          out_data_d = give_word(rd.head);
          out_last_d = (remain_q == CNT_W'(1));
          remain_d   = remain_q - CNT_W'(1);
          if (remain_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded only when a new result is formed.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
      out_last_q   <= out_last_d;
      out_occ_q    <= OCC_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_occ_q, out_data_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/core/cdeq_checker.sv =====
`timescale 1ns / 1ps
`include "circular_double_ended_queue_top_assert.svh"

module cdeq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [cdeq_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [cdeq_pkg::STATUS_W-1:0]  m_axis_tuser,
  input logic                           m_axis_tlast
);
  import cdeq_pkg::*;

  logic [OCC_W-1:0]      occ;
  logic [OUT_DATA_W-1:0] word;
  logic                  err_res;

  assign occ     = m_axis_tdata[OUT_DATA_W+OCC_W-1:OUT_DATA_W];
  assign word    = m_axis_tdata[OUT_DATA_W-1:0];
  assign err_res = m_axis_tvalid && (m_axis_tuser != STATUS_OK);

  // A stalled result stays on the bus unchanged.
  `CDEQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // No input transfer is taken while a result is stalled.
  `CDEQ_ASSERT_SAME(a_no_accept_on_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

  // An error or empty status stands alone, with zero data.
  `CDEQ_ASSERT_SAME(a_err_alone, err_res, m_axis_tlast && (word == '0))

  // Overflow only on a full queue.
  `CDEQ_ASSERT_SAME(a_overflow_full, m_axis_tvalid && (m_axis_tuser == STATUS_OVERFLOW),
    occ == OCC_W'(DEPTH))

  // Underflow and empty read-out only on an empty queue.
  `CDEQ_ASSERT_SAME(a_empty_occ,
    m_axis_tvalid && ((m_axis_tuser == STATUS_UNDERFLOW) || (m_axis_tuser == STATUS_EMPTY)),
    occ == '0)

endmodule

bind circular_double_ended_queue_top cdeq_checker u_cdeq_checker (.*);
